FILE: hw/rtl/jse_pkg.sv
// Package for the JSON string escaper: byte codes, UTF-8 lead decoding and
// the escape expansion of one ASCII byte. Depends on nothing.
package jse_pkg;

    localparam int RunMax = 15;   // longest run of output bytes per input byte
    localparam int TailMax = 6;   // longest escape of one ASCII byte

    // ASCII codes with an escape of their own
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_FF        = 8'h0c;
    localparam logic [7:0] CH_LF        = 8'h0a;
    localparam logic [7:0] CH_CR        = 8'h0d;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_N   = 8'h6e;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;

    // UTF-8 bounds
    localparam logic [7:0] UTF_FIRST_HIGH = 8'h80;
    localparam logic [7:0] CONT_LO        = 8'h80;
    localparam logic [7:0] CONT_HI        = 8'hbf;
    localparam logic [7:0] LEAD2_LO       = 8'hc2;
    localparam logic [7:0] LEAD2_HI       = 8'hdf;
    localparam logic [7:0] LEAD3_E0       = 8'he0;
    localparam logic [7:0] LEAD3_E0_LO    = 8'ha0;
    localparam logic [7:0] LEAD3_ED       = 8'hed;
    localparam logic [7:0] LEAD3_ED_HI    = 8'h9f;
    localparam logic [7:0] LEAD3_HI       = 8'hef;
    localparam logic [7:0] LEAD4_F0       = 8'hf0;
    localparam logic [7:0] LEAD4_F0_LO    = 8'h90;
    localparam logic [7:0] LEAD4_F4       = 8'hf4;
    localparam logic [7:0] LEAD4_F4_HI    = 8'h8f;

    // Replacement character U+FFFD in UTF-8, first byte in element 0
    localparam logic [0:2][7:0] REPL = {8'hef, 8'hbf, 8'hbd};

    typedef struct packed {
        logic [2:0] need;  // sequence length, 0 if not a lead byte
        logic [7:0] lo;    // allowed second byte range
        logic [7:0] hi;
    } t_lead;

    typedef struct packed {
        logic [2:0]       len;
        logic [5:0][7:0]  b;   // byte i in element i
    } t_esc;

    // Decode a lead byte
    function automatic t_lead lead_info(logic [7:0] c);
        t_lead r;
        r.need = 3'd0;
        r.lo   = CONT_LO;
        r.hi   = CONT_HI;
        if (c >= LEAD2_LO && c <= LEAD2_HI) begin
            r.need = 3'd2;
        end else if (c == LEAD3_E0) begin
            r.need = 3'd3;
            r.lo   = LEAD3_E0_LO;
        end else if (c == LEAD3_ED) begin
            r.need = 3'd3;
            r.hi   = LEAD3_ED_HI;
        end else if (c > LEAD3_E0 && c <= LEAD3_HI) begin
            r.need = 3'd3;
        end else if (c == LEAD4_F0) begin
            r.need = 3'd4;
            r.lo   = LEAD4_F0_LO;
        end else if (c == LEAD4_F4) begin
            r.need = 3'd4;
            r.hi   = LEAD4_F4_HI;
        end else if (c > LEAD4_F0 && c < LEAD4_F4) begin
            r.need = 3'd4;
        end
        return r;
    endfunction

    // Lower-case hex digit of a nibble
    function automatic logic [7:0] hex_digit(logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10) begin
            r = CH_ZERO + {4'd0, n};
        end else begin
            r = CH_LOWER_A + {4'd0, n - 4'd10};
        end
        return r;
    endfunction

    // Escape one byte below 0x80
    function automatic t_esc escape_ascii(logic [7:0] c);
        t_esc r;
        r.b    = '0;
        r.len  = 3'd2;
        r.b[0] = CH_BACKSLASH;
        case (c)
            CH_QUOTE:     r.b[1] = CH_QUOTE;
            CH_BACKSLASH: r.b[1] = CH_BACKSLASH;
            CH_BS:        r.b[1] = CH_LOWER_B;
            CH_FF:        r.b[1] = CH_LOWER_F;
            CH_LF:        r.b[1] = CH_LOWER_N;
            CH_CR:        r.b[1] = CH_LOWER_R;
            CH_TAB:       r.b[1] = CH_LOWER_T;
            default: begin
                if (c < CH_SPACE) begin
                    r.len  = 3'd6;
                    r.b[1] = CH_LOWER_U;
                    r.b[2] = CH_ZERO;
                    r.b[3] = CH_ZERO;
                    r.b[4] = hex_digit(c[7:4]);
                    r.b[5] = hex_digit(c[3:0]);
                end else begin
                    r.len  = 3'd1;
                    r.b[0] = c;
                end
            end
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/jse_in_if.sv
// Input channel of the JSON string escaper: one raw string byte per request.
// Depends on nothing.
interface jse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_final;

    modport source (output valid, output in_byte, output in_final, input ready);
    modport sink   (input valid, input in_byte, input in_final, output ready);
endinterface

FILE: hw/rtl/jse_out_if.sv
// Output channel of the JSON string escaper: one escaped byte per request.
// Depends on nothing.
interface jse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_run_end;
    logic       out_string_end;

    modport source (output valid, output out_byte, output out_run_end,
                    output out_string_end, input ready);
    modport sink   (input valid, input out_byte, input out_run_end,
                    input out_string_end, output ready);
endinterface

FILE: hw/rtl/json_string_escape_utf8.sv
// JSON string body escaper with UTF-8 checking; uses jse_pkg, jse_in_if and
// jse_out_if.
//
// Each accepted input byte is expanded combinationally into a run of 0 to 15
// output bytes that is loaded into a shift register and sent one byte per
// cycle while o_out.ready is high. A new input byte is taken in the cycle in
// which the last byte of the previous run leaves, so plain ASCII flows at one
// byte per clock while the output is not stalled. Bytes of an unfinished
// UTF-8 sequence are held internally and give no output until the sequence
// completes or breaks; out_run_end marks the last byte of each run and
// out_string_end the last byte caused by a final input byte.
module json_string_escape_utf8 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jse_in_if.sink      i_in,
    jse_out_if.source   o_out
);

    // Pending sequence state
    logic [7:0]  r_held [0:2];
    logic [1:0]  r_cnt;
    logic [2:0]  r_need;
    logic [1:0]  n_cnt;
    logic [2:0]  n_need;
    logic        held_wr;
    logic [1:0]  held_idx;

    // Output run
    logic [7:0]  r_run [0:jse_pkg::RunMax-1];
    logic [3:0]  r_left;
    logic        r_final;
    logic [7:0]  n_run [0:jse_pkg::RunMax-1];
    logic [3:0]  n_total;

    logic        in_acc;
    logic        out_acc;

    // Hand shakes
    assign out_acc       = o_out.valid && o_out.ready;
    assign i_in.ready    = (r_left == 4'd0) || ((r_left == 4'd1) && o_out.ready);
    assign in_acc        = i_in.valid && i_in.ready;
    assign o_out.valid          = (r_left != 4'd0);
    assign o_out.out_byte       = r_run[0];
    assign o_out.out_run_end    = (r_left == 4'd1);
    assign o_out.out_string_end = (r_left == 4'd1) && r_final;

    // Work out the run and the next pending state for the offered byte
    always_comb begin
        jse_pkg::t_lead  plead;
        jse_pkg::t_lead  flead;
        jse_pkg::t_esc   esc;
        logic [7:0]      c;
        logic [7:0]      lo;
        logic [7:0]      hi;
        logic            ok;
        logic [1:0]      n_repl;
        logic [5:0][7:0] tail;
        logic [2:0]      tail_len;
        logic [3:0]      off;
        logic [3:0]      idx;

        c        = i_in.in_byte;
        plead    = jse_pkg::lead_info(r_held[0]);
        flead    = jse_pkg::lead_info(c);
        esc      = jse_pkg::escape_ascii(c);
        lo       = (r_cnt == 2'd1) ? plead.lo : jse_pkg::CONT_LO;
        hi       = (r_cnt == 2'd1) ? plead.hi : jse_pkg::CONT_HI;
        ok       = (r_cnt != 2'd0) && ({1'b0, r_cnt} < r_need) && (c >= lo) && (c <= hi);
        n_cnt    = r_cnt;
        n_need   = r_need;
        held_wr  = 1'b0;
        held_idx = r_cnt;
        n_repl   = 2'd0;
        tail     = '0;
        tail_len = 3'd0;

        if (ok && ({1'b0, r_cnt} + 3'd1 == r_need)) begin
            // Sequence complete: pass held bytes and this one
            for (int i = 0; i < 4; i++) begin
                if (2'(i) < r_cnt) begin
                    tail[i] = r_held[i];
                end else if (2'(i) == r_cnt) begin
                    tail[i] = c;
                end
            end
            tail_len = {1'b0, r_cnt} + 3'd1;
            n_cnt    = 2'd0;
            n_need   = 3'd0;
        end else if (ok && !i_in.in_final) begin
            // Hold continuation byte
            held_wr = 1'b1;
            n_cnt   = r_cnt + 2'd1;
        end else if (ok) begin
            // Cut off at the end of the string
            n_repl = r_cnt + 2'd1;
            n_cnt  = 2'd0;
            n_need = 3'd0;
        end else begin
            // Broken or nothing pending: replace held bytes, then start fresh
            n_repl = r_cnt;
            n_cnt  = 2'd0;
            n_need = 3'd0;
            if (c < jse_pkg::UTF_FIRST_HIGH) begin
                tail     = esc.b;
                tail_len = esc.len;
            end else if ((flead.need == 3'd0) || i_in.in_final) begin
                tail[0]  = jse_pkg::REPL[0];
                tail[1]  = jse_pkg::REPL[1];
                tail[2]  = jse_pkg::REPL[2];
                tail_len = 3'd3;
            end else begin
                held_wr  = 1'b1;
                held_idx = 2'd0;
                n_cnt    = 2'd1;
                n_need   = flead.need;
            end
        end

        if (i_in.in_final) begin
            n_cnt  = 2'd0;
            n_need = 3'd0;
        end

        // Replacement characters first, then the tail
        off     = {2'b00, n_repl} + {1'b0, n_repl, 1'b0};
        n_total = off + {1'b0, tail_len};
        for (int k = 0; k < jse_pkg::RunMax; k++) begin
            idx = 4'(k) - off;
            if (4'(k) < off) begin
                n_run[k] = jse_pkg::REPL[k % 3];
            end else if (idx < 4'(jse_pkg::TailMax)) begin
                n_run[k] = tail[idx[2:0]];
            end else begin
                n_run[k] = 8'h00;
            end
        end
    end

    // Hold pending bytes
    always_ff @(posedge i_clk) begin
        if (in_acc && held_wr) begin
            r_held[held_idx] <= i_in.in_byte;
        end
    end

    // Advance pending state and the output run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_need <= 3'd0;
            r_left <= 4'd0;
        end else begin
            if (in_acc) begin
                r_cnt  <= n_cnt;
                r_need <= n_need;
                r_left <= n_total;
            end else if (out_acc) begin
                r_left <= r_left - 4'd1;
            end
        end
    end

    // Load or shift the run bytes
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_run   <= n_run;
            r_final <= i_in.in_final;
        end else if (out_acc) begin
            for (int k = 0; k < jse_pkg::RunMax - 1; k++) begin
                r_run[k] <= r_run[k+1];
            end
        end
    end

`ifndef SYNTHESIS
    a_need_above_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd0) |-> ({1'b0, r_cnt} < r_need))
        else $error("pending count not below sequence length");

    a_idle_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_need == 3'd0))
        else $error("sequence length set with nothing pending");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.in_final) |=> (r_cnt == 2'd0))
        else $error("pending bytes left after final byte");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ((r_left == 4'd0) || ((r_left == 4'd1) && out_acc)))
        else $error("request taken while run still in flight");

    a_run_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !in_acc) |=> (r_left == $past(r_left) - 4'd1))
        else $error("run length did not drop on output request");
`endif

endmodule
